### rtl/core/csvtok_pkg.sv
// csvtok_pkg: shared constants, register codes and types of the csv tokenizer
// no dependencies; used by the interfaces, csvtok_step and csv_tokenizer_core
`timescale 1ns / 1ps

package csvtok_pkg;

	// design constants
	localparam int CHAR_BITS    = 16;
	localparam int COLUMN_LIMIT = 64;
	localparam int COUNT_BITS   = 16;

	// fixed field widths of the ports
	localparam int CHAR_W     = 16;
	localparam int COLIDX_W   = 6;
	localparam int STATUS_W   = 3;
	localparam int FIELD_W    = 16;
	localparam int COLUMNS_W  = 7;
	localparam int ROWS_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// derived widths
	localparam int COL_BITS     = $clog2(COLUMN_LIMIT + 1);
	localparam int LIM_BITS     = (COL_BITS > COLUMNS_W) ? COL_BITS : COLUMNS_W;
	localparam int CNT_CMP_BITS = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

	// register reset values
	localparam logic [FIELD_W-1:0]   MAX_FIELD_CHARS_RST = FIELD_W'(32768);
	localparam logic [COLUMNS_W-1:0] MAX_COLUMNS_RST     = COLUMNS_W'(64);
	localparam logic [ROWS_W-1:0]    MAX_ROWS_RST        = ROWS_W'(1000);

	// special characters
	localparam logic [CHAR_BITS-1:0] CH_QUOTE = CHAR_BITS'(8'h22);
	localparam logic [CHAR_BITS-1:0] CH_COMMA = CHAR_BITS'(8'h2C);
	localparam logic [CHAR_BITS-1:0] CH_CR    = CHAR_BITS'(8'h0D);
	localparam logic [CHAR_BITS-1:0] CH_LF    = CHAR_BITS'(8'h0A);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_FIELD_CHARS = 2'd0,
		REG_MAX_COLUMNS     = 2'd1,
		REG_MAX_ROWS        = 2'd2
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_ROW_OR_FIELD = 3'd1,
		ST_FIELD        = 3'd2,
		ST_ROWS         = 3'd3,
		ST_QUOTE        = 3'd4
	} status_t;

	typedef struct packed {
		logic [FIELD_W-1:0]   max_field_chars;
		logic [COLUMNS_W-1:0] max_columns;
		logic [ROWS_W-1:0]    max_rows;
	} cfg_t;

	typedef struct packed {
		logic                  in_quotes;
		logic                  quote_pending;
		logic                  cr_pending;
		logic [COUNT_BITS-1:0] field_length;
		logic [COL_BITS-1:0]   fields_in_row;
		logic                  row_has_value;
		logic [COUNT_BITS-1:0] kept_rows;
		status_t               error_code;
	} state_t;

	typedef struct packed {
		logic                 valid;
		logic [CHAR_BITS-1:0] ch;
		logic [COL_BITS-1:0]  col;
		logic                 fend;
		logic                 rend;
		logic                 kept;
	} tok_t;

	typedef struct packed {
		logic                char_valid;
		logic [CHAR_W-1:0]   char_out;
		logic [COLIDX_W-1:0] column_index;
		logic                field_end;
		logic                row_end;
		logic                row_kept;
		logic                text_done;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

### rtl/core/csvtok_if.sv
// csvtok_in_if and csvtok_out_if: valid/ready channels of the csv tokenizer
// depends on csvtok_pkg for field widths
`timescale 1ns / 1ps

interface csvtok_in_if;
	logic                          valid;
	logic                          ready;
	logic [csvtok_pkg::CHAR_W-1:0] char_in;
	logic                          text_last;

	modport source (output valid, output char_in, output text_last, input ready);
	modport sink (input valid, input char_in, input text_last, output ready);
endinterface

interface csvtok_out_if;
	logic                            valid;
	logic                            ready;
	logic                            char_valid;
	logic [csvtok_pkg::CHAR_W-1:0]   char_out;
	logic [csvtok_pkg::COLIDX_W-1:0] column_index;
	logic                            field_end;
	logic                            row_end;
	logic                            row_kept;
	logic                            text_done;
	logic [csvtok_pkg::STATUS_W-1:0] status;

	modport source (
		output valid, output char_valid, output char_out, output column_index,
		output field_end, output row_end, output row_kept, output text_done,
		output status, input ready
	);
	modport sink (
		input valid, input char_valid, input char_out, input column_index,
		input field_end, input row_end, input row_kept, input text_done,
		input status, output ready
	);
endinterface

### rtl/core/csvtok_step.sv
// csvtok_step: per-character next-state and token logic of the csv tokenizer
// depends on csvtok_pkg
`timescale 1ns / 1ps

module csvtok_step (
	input  csvtok_pkg::state_t                st,
	input  logic [csvtok_pkg::CHAR_W-1:0]     char_in,
	input  logic                              text_last,
	input  csvtok_pkg::cfg_t                  cfg,
	output csvtok_pkg::state_t                nst,
	output csvtok_pkg::result_t               res
);
	import csvtok_pkg::*;

	typedef struct packed {
		state_t st;
		tok_t   tk;
		logic   ok;
	} work_t;

	logic [LIM_BITS-1:0]     lim;
	logic [CNT_CMP_BITS-1:0] mfc;
	logic [CNT_CMP_BITS-1:0] mrows;

	function automatic work_t add_char(work_t w, logic [CHAR_BITS-1:0] c);
		work_t r;
		r = w;
		r.tk.valid = 1'b1;
		r.tk.ch    = c;
		if (r.st.field_length != '1)
			r.st.field_length = r.st.field_length + COUNT_BITS'(1);
		return r;
	endfunction

	function automatic work_t end_field(work_t w, logic [LIM_BITS-1:0] l,
			logic [CNT_CMP_BITS-1:0] m);
		work_t r;
		r = w;
		r.ok = 1'b0;
		if (r.st.error_code == ST_OK) begin
			if (CNT_CMP_BITS'(r.st.field_length) > m ||
					LIM_BITS'(r.st.fields_in_row) >= l) begin
				r.st.error_code = ST_ROW_OR_FIELD;
			end else begin
				if (r.st.field_length != '0)
					r.st.row_has_value = 1'b1;
				r.tk.col            = r.st.fields_in_row;
				r.tk.fend           = 1'b1;
				r.st.fields_in_row  = r.st.fields_in_row + COL_BITS'(1);
				r.st.field_length   = '0;
				r.ok                = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic work_t end_row(work_t w, logic [LIM_BITS-1:0] l,
			logic [CNT_CMP_BITS-1:0] m, logic [CNT_CMP_BITS-1:0] mr);
		work_t r;
		logic  close;
		r = end_field(w, l, m);
		close = r.ok;
		if (r.ok && r.st.row_has_value) begin
			if (CNT_CMP_BITS'(r.st.kept_rows) > mr) begin
				// too many kept rows
				r.st.error_code = ST_ROWS;
				close = 1'b0;
			end else begin
				if (r.st.kept_rows != '1)
					r.st.kept_rows = r.st.kept_rows + COUNT_BITS'(1);
				r.tk.kept = 1'b1;
			end
		end
		if (close) begin
			r.tk.rend          = 1'b1;
			r.st.fields_in_row = '0;
			r.st.row_has_value = 1'b0;
		end
		return r;
	endfunction

	assign lim = (LIM_BITS'(cfg.max_columns) < LIM_BITS'(COLUMN_LIMIT)) ?
		LIM_BITS'(cfg.max_columns) : LIM_BITS'(COLUMN_LIMIT);
	assign mfc   = CNT_CMP_BITS'(cfg.max_field_chars);
	assign mrows = CNT_CMP_BITS'(cfg.max_rows);

	always_comb begin
		work_t                w;
		logic                 done;
		logic [CHAR_BITS-1:0] c;
		c    = char_in[CHAR_BITS-1:0];
		w    = '0;
		w.st = st;
		done = 1'b0;

		if (w.st.error_code == ST_OK) begin
			// lf right after cr is swallowed
			if (w.st.cr_pending) begin
				w.st.cr_pending = 1'b0;
				if (c == CH_LF)
					done = 1'b1;
			end
			// quote inside quotes waits for this character
			if (!done && w.st.quote_pending) begin
				w.st.quote_pending = 1'b0;
				if (c == CH_QUOTE) begin
					w    = add_char(w, CH_QUOTE);
					done = 1'b1;
				end else begin
					w.st.in_quotes = 1'b0;
				end
			end
			if (!done) begin
				if (w.st.in_quotes) begin
					if (c == CH_QUOTE) begin
						if (text_last)
							w.st.in_quotes = 1'b0;
						else
							w.st.quote_pending = 1'b1;
					end else begin
						w = add_char(w, c);
					end
				end else begin
					if (c == CH_QUOTE && w.st.field_length == '0) begin
						w.st.in_quotes = 1'b1;
					end else if (c == CH_COMMA) begin
						w = end_field(w, lim, mfc);
					end else if (c == CH_CR || c == CH_LF) begin
						if (c == CH_CR && !text_last)
							w.st.cr_pending = 1'b1;
						w = end_row(w, lim, mfc, mrows);
					end else begin
						w = add_char(w, c);
					end
					if (w.st.error_code == ST_OK &&
							CNT_CMP_BITS'(w.st.field_length) > mfc)
						w.st.error_code = ST_FIELD;
				end
			end
		end

		// final beat flushes the open row
		if (text_last && w.st.error_code == ST_OK) begin
			if (w.st.in_quotes)
				w.st.error_code = ST_QUOTE;
			else if (w.st.field_length != '0 || w.st.fields_in_row != '0)
				w = end_row(w, lim, mfc, mrows);
		end

		if (w.st.error_code != ST_OK)
			w.tk = '0;

		res.char_valid   = w.tk.valid;
		res.char_out     = CHAR_W'(w.tk.ch);
		res.column_index = COLIDX_W'(w.tk.col);
		res.field_end    = w.tk.fend;
		res.row_end      = w.tk.rend;
		res.row_kept     = w.tk.kept;
		res.text_done    = text_last;
		res.status       = STATUS_W'(w.st.error_code);

		nst = text_last ? state_t'('0) : w.st;
	end

endmodule

### rtl/core/csv_tokenizer_core.sv
// csv_tokenizer_core: top level of the streaming csv tokenizer
// depends on csvtok_pkg, csvtok_in_if, csvtok_out_if and csvtok_step
`timescale 1ns / 1ps

// Streaming CSV tokenizer: one character per beat in, exactly one result beat
// out per character. Each result tags its character as field content, field
// end and/or row end, marks rows whose fields are all empty as dropped
// (row_kept low), and carries the sticky status code. Quotes open a quoted
// field only at field start, a doubled quote inside quotes is one literal
// quote, and CR, LF or CR LF each end a row. The beat with text_last flushes
// the open row, reports text_done and returns all parse state to reset.
// Throughput is one character per clock while the result side keeps taking
// results. A result passes through the input register, then the result
// register, and a stall on the output can hold it between them. The figure
// is set by the per-character state update, which is one pass of
// combinational logic between the two registers.
// While a finished result waits, the input register takes at most one more
// beat; after that ready stays low until the waiting result is taken.
// Limit registers are written through wr_en / wr_index / wr_data and should
// only be changed while no beat is in flight.

module csv_tokenizer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [csvtok_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [csvtok_pkg::CFG_DATA_W-1:0] wr_data,
	csvtok_in_if.sink                         text_in,
	csvtok_out_if.source                      token_out
);
	import csvtok_pkg::*;

	// limit registers
	cfg_t cfg_q;

	// parse state, advanced once per character
	state_t state_q;
	state_t state_next;

	// input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	// result stage
	logic    valid_s2;
	result_t res_s2;
	result_t res_next;

	logic advance;
	logic step;

	// result register frees when empty or being taken
	assign advance       = !valid_s2 || token_out.ready;
	assign step          = valid_s1 && advance;
	assign text_in.ready = !valid_s1 || advance;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_field_chars <= MAX_FIELD_CHARS_RST;
			cfg_q.max_columns     <= MAX_COLUMNS_RST;
			cfg_q.max_rows        <= MAX_ROWS_RST;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_MAX_FIELD_CHARS: cfg_q.max_field_chars <= FIELD_W'(wr_data);
				REG_MAX_COLUMNS:     cfg_q.max_columns     <= COLUMNS_W'(wr_data);
				REG_MAX_ROWS:        cfg_q.max_rows        <= ROWS_W'(wr_data);
				default:             ; // unused index, write ignored
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			char_s1 <= text_in.char_in;
			last_s1 <= text_in.text_last;
		end
	end

	// per-character tokenizer logic
	csvtok_step u_step (
		.st        (state_q),
		.char_in   (char_s1),
		.text_last (last_s1),
		.cfg       (cfg_q),
		.nst       (state_next),
		.res       (res_next)
	);

	// parse state and result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (step)
				state_q <= state_next;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res_next;
	end

	assign token_out.valid        = valid_s2;
	assign token_out.char_valid   = res_s2.char_valid;
	assign token_out.char_out     = res_s2.char_out;
	assign token_out.column_index = res_s2.column_index;
	assign token_out.field_end    = res_s2.field_end;
	assign token_out.row_end      = res_s2.row_end;
	assign token_out.row_kept     = res_s2.row_kept;
	assign token_out.text_done    = res_s2.text_done;
	assign token_out.status       = res_s2.status;

endmodule

### verif/csvtok_token_checker.sv
// csvtok_token_checker: watches the text and token channels of csv_tokenizer_core,
// predicts every token beat from its own copy of the parse state and compares them
// depends on csvtok_pkg and the channel interfaces in csvtok_if.sv
`timescale 1ns / 1ps

module csvtok_token_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [csvtok_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [csvtok_pkg::CFG_DATA_W-1:0] wr_data,
	csvtok_in_if                              text_in,
	csvtok_out_if                             token_out,
	output int                                mismatches,
	output int                                pending,
	output int                                checked
);
	import csvtok_pkg::*;

	localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;

	// limit registers as last written
	int lim_field_chars;
	int lim_columns;
	int lim_rows;

	// parse state
	bit      quoted;
	bit      quote_held;
	bit      cr_held;
	int      field_chars;
	int      field_count;
	bit      row_nonempty;
	int      rows_kept;
	status_t sticky_status;

	result_t tk;
	result_t expected_tokens[$];

	function automatic void clear_parse();
		quoted        = 1'b0;
		quote_held    = 1'b0;
		cr_held       = 1'b0;
		field_chars   = 0;
		field_count   = 0;
		row_nonempty  = 1'b0;
		rows_kept     = 0;
		sticky_status = ST_OK;
	endfunction

	function automatic void take_char(input logic [CHAR_W-1:0] c);
		tk.char_valid = 1'b1;
		tk.char_out   = c;
		if (field_chars < COUNT_MAX) field_chars++;
	endfunction

	function automatic bit close_field();
		int col_cap;
		col_cap = (lim_columns < COLUMN_LIMIT) ? lim_columns : COLUMN_LIMIT;
		if (sticky_status != ST_OK) return 1'b0;
		if (field_chars > lim_field_chars || field_count >= col_cap) begin
			sticky_status = ST_ROW_OR_FIELD;
			return 1'b0;
		end
		if (field_chars != 0) row_nonempty = 1'b1;
		tk.column_index = COLIDX_W'(field_count);
		tk.field_end    = 1'b1;
		field_count++;
		field_chars = 0;
		return 1'b1;
	endfunction

	function automatic void close_row();
		if (!close_field()) return;
		if (row_nonempty) begin
			if (rows_kept > lim_rows) begin
				sticky_status = ST_ROWS;
				return;
			end
			if (rows_kept < COUNT_MAX) rows_kept++;
			tk.row_kept = 1'b1;
		end
		tk.row_end   = 1'b1;
		field_count  = 0;
		row_nonempty = 1'b0;
	endfunction

	function automatic void plain_char(input logic [CHAR_W-1:0] c, input logic is_last);
		if (c == CH_QUOTE && field_chars == 0) begin
			quoted = 1'b1;
		end else if (c == CH_COMMA) begin
			void'(close_field());
		end else if (c == CH_CR || c == CH_LF) begin
			if (c == CH_CR && !is_last) cr_held = 1'b1;
			close_row();
		end else begin
			take_char(c);
		end
		if (sticky_status == ST_OK && field_chars > lim_field_chars) sticky_status = ST_FIELD;
	endfunction

	// token beat caused by one character beat
	function automatic result_t tokenize_char(input logic [CHAR_W-1:0] c, input logic is_last);
		bit      consumed;
		result_t r;
		tk       = '0;
		consumed = 1'b0;
		if (sticky_status == ST_OK) begin
			if (cr_held) begin
				cr_held = 1'b0;
				if (c == CH_LF) consumed = 1'b1;
			end
			if (!consumed && quote_held) begin
				quote_held = 1'b0;
				if (c == CH_QUOTE) begin
					take_char(CH_QUOTE);
					consumed = 1'b1;
				end else begin
					quoted = 1'b0;
				end
			end
			if (!consumed) begin
				if (quoted) begin
					if (c == CH_QUOTE) begin
						if (is_last) quoted = 1'b0;
						else quote_held = 1'b1;
					end else begin
						take_char(c);
					end
				end else begin
					plain_char(c, is_last);
				end
			end
		end
		if (is_last && sticky_status == ST_OK) begin
			if (quoted) sticky_status = ST_QUOTE;
			else if (field_chars != 0 || field_count != 0) close_row();
		end
		if (sticky_status != ST_OK) tk = '0;
		r           = tk;
		r.text_done = is_last;
		r.status    = sticky_status;
		if (is_last) clear_parse();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] want,
		input logic [15:0] got);
		$display("%0t: token %0d %s expected %0h got %0h", $realtime, checked, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			lim_field_chars = int'(MAX_FIELD_CHARS_RST);
			lim_columns     = int'(MAX_COLUMNS_RST);
			lim_rows        = int'(MAX_ROWS_RST);
			clear_parse();
			expected_tokens.delete();
			mismatches = 0;
			pending    = 0;
			checked    = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_MAX_FIELD_CHARS: lim_field_chars = int'(wr_data[FIELD_W-1:0]);
					REG_MAX_COLUMNS:     lim_columns = int'(wr_data[COLUMNS_W-1:0]);
					REG_MAX_ROWS:        lim_rows = int'(wr_data[ROWS_W-1:0]);
					default: ;
				endcase
			end
			if (token_out.valid && token_out.ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch("unexpected beat", 16'h0, 16'h0);
				end else begin
					want = expected_tokens.pop_front();
					if (token_out.char_valid !== want.char_valid)
						report_mismatch("char_valid", 16'(want.char_valid),
							16'(token_out.char_valid));
					if (token_out.char_out !== want.char_out)
						report_mismatch("char_out", want.char_out, token_out.char_out);
					if (token_out.column_index !== want.column_index)
						report_mismatch("column_index", 16'(want.column_index),
							16'(token_out.column_index));
					if (token_out.field_end !== want.field_end)
						report_mismatch("field_end", 16'(want.field_end),
							16'(token_out.field_end));
					if (token_out.row_end !== want.row_end)
						report_mismatch("row_end", 16'(want.row_end),
							16'(token_out.row_end));
					if (token_out.row_kept !== want.row_kept)
						report_mismatch("row_kept", 16'(want.row_kept),
							16'(token_out.row_kept));
					if (token_out.text_done !== want.text_done)
						report_mismatch("text_done", 16'(want.text_done),
							16'(token_out.text_done));
					if (token_out.status !== want.status)
						report_mismatch("status", 16'(want.status),
							16'(token_out.status));
				end
				checked++;
			end
			if (text_in.valid && text_in.ready)
				expected_tokens.insert(expected_tokens.size(),
					tokenize_char(text_in.char_in, text_in.text_last));
			pending = expected_tokens.size();
		end
	end

endmodule

### verif/tb_csv_tokenizer_core.sv
// tb_csv_tokenizer_core: drives csv text into csv_tokenizer_core and gives the verdict
// depends on csvtok_pkg, csvtok_if.sv, csv_tokenizer_core and csvtok_token_checker
`timescale 1ns / 1ps

module tb_csv_tokenizer_core;
	import csvtok_pkg::*;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	csvtok_in_if  text_ch ();
	csvtok_out_if token_ch ();

	int mismatches;
	int pending;
	int checked;

	// stimulus bookkeeping
	logic [CHAR_W-1:0] text_buf[$];
	bit idle_en;
	bit hold_out;
	int beats;
	int texts;
	int settings;

	csv_tokenizer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.text_in   (text_ch),
		.token_out (token_ch)
	);

	csvtok_token_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.text_in    (text_ch),
		.token_out  (token_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit: far above the slowest legal run of ~2000 beats with full gaps
	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// append one character to the text being built
	function automatic void put_char(input logic [CHAR_W-1:0] c);
		text_buf.insert(text_buf.size(), c);
	endfunction

	// any character that is not a quote, comma, cr or lf; mostly lower case,
	// sometimes a full 16-bit code unit so every input bit toggles
	function automatic logic [CHAR_W-1:0] ordinary_char();
		logic [CHAR_W-1:0] c;
		do begin
			if ($urandom_range(0, 2) == 0) c = CHAR_W'($urandom);
			else c = CHAR_W'($urandom_range(8'h61, 8'h7a));
		end while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
		return c;
	endfunction

	// one field: empty, unquoted or quoted; quoted content carries commas,
	// line breaks and doubled quotes; a few are left open or get trailing junk
	function automatic void add_field();
		int n;
		case ($urandom_range(0, 9))
			0, 1: ;
			7, 8, 9: begin
				put_char(CH_QUOTE);
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 9))
						0: begin
							put_char(CH_QUOTE);
							put_char(CH_QUOTE);
						end
						1: put_char(CH_COMMA);
						2: put_char(CH_CR);
						3: put_char(CH_LF);
						default: put_char(ordinary_char());
					endcase
				end
				// unterminated quote now and then
				if ($urandom_range(0, 11) != 0) put_char(CH_QUOTE);
				// content after the closing quote
				if ($urandom_range(0, 9) == 0) put_char(ordinary_char());
			end
			default: begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					// a quote that is not at field start is plain content
					if (i != 0 && $urandom_range(0, 14) == 0) put_char(CH_QUOTE);
					else put_char(ordinary_char());
				end
			end
		endcase
	endfunction

	// one whole text: mostly well formed rows, sometimes raw noise
	function automatic void build_text();
		int n_rows;
		int n_fields;
		int n;
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 7))
					0: put_char(CH_QUOTE);
					1: put_char(CH_COMMA);
					2: put_char(CH_CR);
					3: put_char(CH_LF);
					default: put_char(ordinary_char());
				endcase
			end
		end else begin
			n_rows = $urandom_range(1, 6);
			for (int r = 0; r < n_rows; r++) begin
				// rare wide rows reach the column limit of 64
				n_fields = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70)
					: $urandom_range(1, 6);
				for (int f = 0; f < n_fields; f++) begin
					if (f != 0) put_char(CH_COMMA);
					add_field();
				end
				// the last row is left open half the time so the final beat flushes it
				if (r != n_rows - 1 || $urandom_range(0, 1) == 1) begin
					case ($urandom_range(0, 2))
						0: put_char(CH_CR);
						1: put_char(CH_LF);
						default: begin
							put_char(CH_CR);
							put_char(CH_LF);
						end
					endcase
				end
			end
		end
		if (text_buf.size() == 0) put_char(CH_LF);
	endfunction

	// one character beat, with an occasional idle burst in front of it;
	// returns at the edge where the beat was taken
	task automatic send_beat(input logic [CHAR_W-1:0] c, input logic is_last);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.char_in   <= c;
		text_ch.text_last <= is_last;
		do @(posedge clk); while (!text_ch.ready);
		beats++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_beat(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
		texts++;
	endtask

	// stop offering and wait for every token beat, then let the pipe drain
	// (two register stages) before anything else happens
	task automatic settle_outputs();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limits(input int field_chars, input int columns, input int rows);
		wr_en    <= 1'b1;
		wr_index <= REG_MAX_FIELD_CHARS;
		wr_data  <= CFG_DATA_W'(field_chars);
		@(posedge clk);
		wr_index <= REG_MAX_COLUMNS;
		wr_data  <= CFG_DATA_W'(columns);
		@(posedge clk);
		wr_index <= REG_MAX_ROWS;
		wr_data  <= CFG_DATA_W'(rows);
		@(posedge clk);
		wr_en <= 1'b0;
		settings++;
	endtask

	// one phase: drain, new limits, then random texts until the beat budget is used
	task automatic run_phase(input int n_beats, input int field_chars, input int columns,
		input int rows, input bit long_hold);
		int stop_at;
		settle_outputs();
		write_limits(field_chars, columns, rows);
		// receiver backs off for a long stretch while the texts keep coming
		if (long_hold) hold_out = 1'b1;
		stop_at = beats + n_beats;
		while (beats < stop_at) begin
			build_text();
			send_text();
		end
	endtask

	// token side: ready with random idle bursts, plus one long hold-off
	initial begin
		token_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_out) begin
				token_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_out = 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				token_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				token_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// directed texts under the reset limits, as {text_last, character}
	logic [CHAR_W:0] directed_beats[25] = '{
		{1'b0, 16'h0041},   // plain content
		{1'b0, 16'hffff},   // all ones code unit
		{1'b0, CH_COMMA},   // field end
		{1'b0, CH_QUOTE},   // opens quoting in an empty field
		{1'b0, CH_QUOTE},   // held quote
		{1'b0, CH_QUOTE},   // doubled quote, one literal quote out
		{1'b0, 16'h0079},
		{1'b0, CH_QUOTE},   // held quote
		{1'b0, CH_COMMA},   // closes quoting, then ends the field
		{1'b0, CH_CR},      // row end, lf may follow
		{1'b0, CH_LF},      // swallowed lf, no token
		{1'b0, CH_COMMA},   // empty field
		{1'b0, CH_LF},      // row of empty fields, dropped
		{1'b0, CH_QUOTE},
		{1'b0, CH_COMMA},   // comma inside quotes is content
		{1'b0, CH_QUOTE},   // held quote
		{1'b0, CH_CR},      // closes quoting, then ends the row
		{1'b0, CH_QUOTE},
		{1'b0, 16'h007a},
		{1'b1, CH_QUOTE},   // quote on the final beat closes at once, then flush
		{1'b0, 16'h0071},
		{1'b1, CH_COMMA},   // trailing comma on the final beat ends two fields
		{1'b1, CH_CR},      // cr as the final beat, no pending lf
		{1'b0, CH_QUOTE},
		{1'b1, 16'h0061}    // text ends inside quotes
	};

	initial begin
		arst_n            <= 1'b0;
		wr_en             <= 1'b0;
		wr_index          <= REG_MAX_FIELD_CHARS;
		wr_data           <= '0;
		text_ch.valid     <= 1'b0;
		text_ch.char_in   <= '0;
		text_ch.text_last <= 1'b0;
		idle_en  = 1'b1;
		hold_out = 1'b0;
		beats    = 0;
		texts    = 0;
		settings = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_beats[i]) begin
			send_beat(directed_beats[i][CHAR_W-1:0], directed_beats[i][CHAR_W]);
			if (directed_beats[i][CHAR_W]) texts++;
		end

		// smallest limits: every error kind shows up early
		run_phase(250, 1, 1, 1, 1'b0);
		// largest legal limits, with the long receiver hold-off
		run_phase(350, 65534, 64, 65534, 1'b1);
		run_phase(300, 3, 4, 2, 1'b0);
		// out of range: zero columns fails every field end, field limit never trips
		run_phase(150, 65535, 0, 0, 1'b0);
		// column register above the built-in limit of 64
		run_phase(300, 8, 127, 5, 1'b0);
		run_phase(250, 65535, 2, 65535, 1'b0);
		// last part: no idling on either side
		settle_outputs();
		idle_en = 1'b0;
		run_phase(325, 16, 8, 3, 1'b0);

		settle_outputs();
		repeat (8) @(posedge clk);

		$display("run covered %0d characters in %0d texts over %0d limit settings",
			beats, texts, settings);
		$display("%0d token beats compared, including a long output stall and drains",
			checked);
		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
